@@ sv/lbp_pkg.sv @@
// Shared types and constants of the 3x3 local binary pattern operator.
`timescale 1ns / 1ps

package lbp_pkg;

    localparam int PIX_W         = 8;
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 12;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             pad;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] lbp_code;
        logic             last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
    } t_lb_word;

endpackage

@@ sv/lbp_3x3_image_operator_unit.sv @@
// Top level of the streaming 3x3 local binary pattern operator.
// Throughput: one item per cycle; input stalls only while a result waits on a stalled output.
// An accepted item waits in stage one; its result is then held in the output register.
// Line buffer: read at accept, written as the item leaves stage one, forwarded on a hit.
// Results lag the pixel stream by frame_width plus one items.
// Synchronous active-low reset clears counters, window, valids and settings, not the line buffer.
`timescale 1ns / 1ps

module lbp_3x3_image_operator_unit #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lbp_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lbp_pkg::t_out_item  o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW > lbp_pkg::WIDTH_W) ? WW : lbp_pkg::WIDTH_W;
    localparam int PW  = lbp_pkg::PIX_W;
    localparam int HW  = lbp_pkg::HEIGHT_W;

    logic [lbp_pkg::WIDTH_W-1:0] r_width;
    logic [HW-1:0]               r_height;
    logic                        cfg_wr;
    lbp_pkg::t_reg_idx           cfg_idx;

    logic [EW-1:0] fw_x;
    logic [EW-1:0] eff_w;
    logic [EW-1:0] w_m1;
    logic [HW-1:0] h_m1;

    logic [CW-1:0] r_in_col;
    logic [1:0]    r_in_row;
    logic [CW-1:0] r_out_col;
    logic [HW-1:0] r_out_row;

    logic          in_acc;
    logic          restart_now;
    logic [CW-1:0] base_col;
    logic [1:0]    base_row;
    logic          col_wrap;
    logic          emit0;
    logic [PW-1:0] pix0;
    logic          hazard;

    logic          r_s1_valid;
    logic [PW-1:0] r_s1_pix;
    logic [CW-1:0] r_s1_col;
    logic          r_s1_emit;
    logic          r_fwd;
    logic [PW-1:0] r_fwd_top;
    logic [PW-1:0] r_fwd_mid;
    logic [PW-1:0] s1_top;
    logic [PW-1:0] s1_mid;
    logic          s1_move;
    logic          s1_last;
    logic          s1_border;

    lbp_pkg::t_lb_word lb_rd;
    lbp_pkg::t_lb_word lb_wr;

    logic [PW-1:0] r_win [9];
    logic [PW-1:0] n_win [9];
    logic [PW-1:0] code;

    logic               r_out_valid;
    lbp_pkg::t_out_item r_out_data;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = lbp_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lbp_pkg::WIDTH_RESET;
            r_height <= lbp_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                lbp_pkg::REG_FRAME_WIDTH:  r_width  <= pwdata[lbp_pkg::WIDTH_W-1:0];
                lbp_pkg::REG_FRAME_HEIGHT: r_height <= pwdata[HW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            lbp_pkg::REG_FRAME_WIDTH:  prdata = 32'(r_width);
            lbp_pkg::REG_FRAME_HEIGHT: prdata = 32'(r_height);
            default:                   prdata = '0;
        endcase
    end

    // Effective frame size.
    always_comb begin
        fw_x = EW'(r_width);
        if (fw_x == '0) begin
            eff_w = EW'(1);
        end else if (fw_x > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = fw_x;
        end
        w_m1 = eff_w - EW'(1);
        h_m1 = (r_height == '0) ? '0 : r_height - HW'(1);
    end

    // Stage one: result side.
    assign s1_last   = r_s1_emit && (r_out_row >= h_m1) && (EW'(r_out_col) >= w_m1);
    assign s1_border = (r_out_row == '0) || (r_out_row >= h_m1) ||
                       (r_out_col == '0) || (EW'(r_out_col) >= w_m1);
    assign s1_move   = r_s1_valid && (!r_s1_emit || !r_out_valid || !i_out_stall);
    assign s1_top    = r_fwd ? r_fwd_top : lb_rd.upper;
    assign s1_mid    = r_fwd ? r_fwd_mid : lb_rd.lower;

    // Input side.
    assign o_in_stall  = r_s1_valid && !s1_move;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign restart_now = s1_move && s1_last;
    assign base_col    = restart_now ? '0 : r_in_col;
    assign base_row    = restart_now ? 2'd0 : r_in_row;
    assign col_wrap    = EW'(base_col) >= w_m1;
    assign emit0       = (base_row == 2'd2) || ((base_row == 2'd1) && (base_col != '0));
    assign pix0        = i_in_data.pad ? '0 : i_in_data.pixel;
    assign hazard      = s1_move && (base_col == r_s1_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= 2'd0;
        end else if (cfg_wr) begin
            r_in_col <= '0;
            r_in_row <= 2'd0;
        end else if (in_acc) begin
            r_in_col <= col_wrap ? '0 : base_col + CW'(1);
            if (col_wrap && (base_row != 2'd2)) begin
                r_in_row <= base_row + 2'd1;
            end else begin
                r_in_row <= base_row;
            end
        end else if (restart_now) begin
            r_in_col <= '0;
            r_in_row <= 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix  <= pix0;
            r_s1_col  <= base_col;
            r_s1_emit <= emit0;
            r_fwd     <= hazard;
            r_fwd_top <= s1_mid;
            r_fwd_mid <= r_s1_pix;
        end
    end

    assign lb_wr.upper = s1_mid;
    assign lb_wr.lower = r_s1_pix;

    lbp_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (base_col),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_col),
        .i_wr_data (lb_wr),
        .o_rd_data (lb_rd)
    );

    // Window shift and pattern.
    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = s1_top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = s1_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_pix;
        code[7] = n_win[0] >= n_win[4];
        code[6] = n_win[1] >= n_win[4];
        code[5] = n_win[2] >= n_win[4];
        code[4] = n_win[5] >= n_win[4];
        code[3] = n_win[8] >= n_win[4];
        code[2] = n_win[7] >= n_win[4];
        code[1] = n_win[6] >= n_win[4];
        code[0] = n_win[3] >= n_win[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_move) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // Output position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (cfg_wr) begin
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (s1_move && r_s1_emit) begin
            if (s1_last) begin
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (EW'(r_out_col) >= w_m1) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + HW'(1);
            end else begin
                r_out_col <= r_out_col + CW'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_emit) begin
            r_out_data.lbp_code      <= s1_border ? n_win[4] : code;
            r_out_data.last_of_frame <= s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // A new result only appears after an emitting item left stage one.
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_emit))
        else $error("result appeared without an emitting item");

    // The output position never runs past the frame.
    a_out_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_row <= h_m1)
        else $error("output row beyond frame height");

    a_out_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_out_col) <= w_m1)
        else $error("output column beyond frame width");
`endif

endmodule

@@ sv/lbp_linebuf.sv @@
// Line buffer memory holding the upper and lower rows side by side in one word.
`timescale 1ns / 1ps

module lbp_linebuf #(
    parameter int DEPTH = lbp_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(lbp_pkg::MAX_WIDTH_DEF)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  lbp_pkg::t_lb_word i_wr_data,
    output lbp_pkg::t_lb_word o_rd_data
);

    lbp_pkg::t_lb_word mem [DEPTH];
    lbp_pkg::t_lb_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sim/lbp_checker.sv @@
// Checker for the 3x3 local binary pattern operator: predicts each result and compares it.
`timescale 1ns / 1ps

module lbp_checker #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  lbp_pkg::t_in_item   i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  lbp_pkg::t_out_item  i_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_results
);

    localparam int PW = lbp_pkg::PIX_W;

    logic [PW-1:0]                line_upper [MAX_WIDTH];
    logic [PW-1:0]                line_lower [MAX_WIDTH];
    logic [PW-1:0]                window [9];
    logic [lbp_pkg::WIDTH_W-1:0]  width_reg;
    logic [lbp_pkg::HEIGHT_W-1:0] height_reg;
    int                           in_col;
    int                           in_row;
    int                           out_col;
    int                           out_row;
    lbp_pkg::t_out_item           lbp_expected_q [$];
    int                           mismatch_cnt = 0;
    int                           result_cnt = 0;

    initial begin
        for (int k = 0; k < MAX_WIDTH; k++) begin
            line_upper[k] = '0;
            line_lower[k] = '0;
        end
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic int active_width();
        int w;
        w = int'(width_reg);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic logic [PW-1:0] window_code();
        logic [PW-1:0] c;
        c = window[4];
        return {window[0] >= c, window[1] >= c, window[2] >= c, window[5] >= c,
                window[8] >= c, window[7] >= c, window[6] >= c, window[3] >= c};
    endfunction

    task automatic restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic predict_lbp(lbp_pkg::t_in_item item);
        int                 w;
        int                 h;
        int                 col;
        logic [PW-1:0]      pix;
        logic [PW-1:0]      top;
        logic [PW-1:0]      mid;
        logic               emit;
        logic               border;
        logic               last;
        lbp_pkg::t_out_item res;
        w   = active_width();
        h   = (height_reg == '0) ? 1 : int'(height_reg);
        pix = item.pad ? '0 : item.pixel;
        col = in_col % MAX_WIDTH;
        top = line_upper[col];
        mid = line_lower[col];
        line_upper[col] = mid;
        line_lower[col] = pix;
        for (int r = 0; r < 3; r++) begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = pix;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            if (in_row < 'hFFFF) in_row++;
        end
        if (emit) begin
            border = (out_row == 0) || (out_row + 1 >= h) || (out_col == 0) || (out_col + 1 >= w);
            last   = (out_row + 1 >= h) && (out_col + 1 >= w);
            res.lbp_code      = border ? window[4] : window_code();
            res.last_of_frame = last;
            lbp_expected_q = {lbp_expected_q, res};
            if (last) begin
                restart_frame();
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        end
    endtask

    task automatic compare_result(lbp_pkg::t_out_item got);
        lbp_pkg::t_out_item want;
        result_cnt++;
        if (lbp_expected_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none due (code %02h, last %0b)",
                                      result_cnt, got.lbp_code, got.last_of_frame));
        end else begin
            want = lbp_expected_q.pop_front();
            if (got.lbp_code !== want.lbp_code) begin
                report_mismatch($sformatf("result %0d lbp_code %02h, predicted %02h",
                                          result_cnt, got.lbp_code, want.lbp_code));
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                report_mismatch($sformatf("result %0d last_of_frame %0b, predicted %0b",
                                          result_cnt, got.last_of_frame, want.last_of_frame));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = lbp_pkg::WIDTH_RESET;
            height_reg = lbp_pkg::HEIGHT_RESET;
            for (int k = 0; k < 9; k++) begin
                window[k] = '0;
            end
            restart_frame();
            lbp_expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == lbp_pkg::REG_FRAME_WIDTH) begin
                    width_reg = pwdata[lbp_pkg::WIDTH_W-1:0];
                end else begin
                    height_reg = pwdata[lbp_pkg::HEIGHT_W-1:0];
                end
                restart_frame();
            end
            if (i_out_valid && !i_out_stall) begin
                compare_result(i_out_data);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_lbp(i_in_data);
            end
        end
        o_errors  <= mismatch_cnt;
        o_pending <= lbp_expected_q.size();
        o_results <= result_cnt;
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the 3x3 local binary pattern operator: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int PW             = lbp_pkg::PIX_W;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    lbp_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    lbp_pkg::t_out_item o_out_data;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [2:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;

    int          mismatches;
    int          pending;
    int          results;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          hold_request  = 1'b0;
    int          hold_left     = 0;
    int          holds_done    = 0;
    int          quiet_cycles  = 0;

    int          frame_w = 1;
    int          frame_h = 1;
    int          items_sent  = 0;
    int          frames_sent = 0;
    int          frames_cut  = 0;
    int          sizes_used  = 0;

    lbp_3x3_image_operator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lbp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_errors    (mismatches),
        .o_pending   (pending),
        .o_results   (results)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(logic [PW-1:0] pix, logic pad);
        lbp_pkg::t_in_item item;
        item.pixel = pix;
        item.pad   = pad;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic apb_write(lbp_pkg::t_reg_idx idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_block_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame_size(int w_reg, int h_reg);
        logic [31:0] data;
        wait_block_idle();
        data = $urandom();
        data[lbp_pkg::WIDTH_W-1:0] = w_reg[lbp_pkg::WIDTH_W-1:0];
        apb_write(lbp_pkg::REG_FRAME_WIDTH, data);
        data = $urandom();
        data[lbp_pkg::HEIGHT_W-1:0] = h_reg[lbp_pkg::HEIGHT_W-1:0];
        apb_write(lbp_pkg::REG_FRAME_HEIGHT, data);
        frame_w = (w_reg == 0) ? 1 :
                  ((w_reg > lbp_pkg::MAX_WIDTH_DEF) ? lbp_pkg::MAX_WIDTH_DEF : w_reg);
        frame_h = (h_reg == 0) ? 1 : h_reg;
        sizes_used++;
    endtask

    function automatic logic [PW-1:0] pick_pixel(logic [PW-1:0] base);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return PW'($urandom_range(0, 255));
        if (sel < 6) return (sel == 4) ? 8'hFF : 8'h00;
        return PW'(int'(base) + $urandom_range(0, 2) - 1);
    endfunction

    task automatic send_frame(int noise_pct);
        logic [PW-1:0] base;
        base = PW'($urandom_range(0, 255));
        for (int i = 0; i < frame_w * frame_h; i++) begin
            send_item(pick_pixel(base), $urandom_range(0, 99) < noise_pct);
        end
        for (int i = 0; i <= frame_w; i++) begin
            send_item(PW'($urandom_range(0, 255)), !($urandom_range(0, 99) < noise_pct));
        end
        frames_sent++;
    endtask

    task automatic send_fixed_frame(logic [PW-1:0] pix [], logic pads []);
        for (int i = 0; i < pix.size(); i++) begin
            send_item(pix[i], pads[i]);
        end
        frames_sent++;
    endtask

    initial begin
        int idle_tab [4];
        int stall_tab [4];
        int iter;
        int w_reg;
        int h_reg;
        int sel;
        int noise;
        int cut_len;
        logic [PW-1:0] pix [];
        logic          pads [];

        idle_tab  = '{0, 55, 0, 31};
        stall_tab = '{0, 0, 55, 31};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Interior pixel with equal, larger and smaller neighbours; one pad inside
        // the frame and one pixel during the flush.
        set_frame_size(3, 3);
        pix  = {8'd200, 8'd100, 8'd255, 8'd99, 8'd100, 8'd101, 8'hAB, 8'd100, 8'd100,
                8'd0, 8'd0, 8'd255, 8'd0};
        pads = {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                1'b1, 1'b1, 1'b0, 1'b1};
        send_fixed_frame(pix, pads);

        // Zero width and zero height act as a single pixel.
        set_frame_size(0, 0);
        pix  = {8'd255, 8'd17, 8'd0};
        pads = {1'b0, 1'b1, 1'b1};
        send_fixed_frame(pix, pads);

        set_frame_size(2, 2);
        pix  = {8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
        pads = {1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
        send_fixed_frame(pix, pads);

        iter = 0;
        while (items_sent < RANDOM_ITEMS) begin
            send_idle_pct = idle_tab[(iter / 3) % 4];
            stall_pct     = stall_tab[(iter / 3) % 4];
            sel = $urandom_range(0, 9);
            w_reg = (sel < 4) ? sel : $urandom_range(4, 16);
            sel = $urandom_range(0, 9);
            h_reg = (sel < 3) ? sel : $urandom_range(3, 8);
            set_frame_size(w_reg, h_reg);
            if (iter == 1 || iter == 7) begin
                hold_request = 1'b1;
            end
            noise = ($urandom_range(0, 5) == 0) ? 10 : 0;
            repeat ($urandom_range(1, 3)) send_frame(noise);
            if ($urandom_range(0, 9) == 0) begin
                cut_len = $urandom_range(1, frame_w * frame_h + frame_w);
                for (int k = 0; k < cut_len; k++) begin
                    send_item(PW'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                end
                frames_cut++;
            end
            iter++;
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d frames (%0d cut short) over %0d frame sizes, %0d input items.",
                 frames_sent, frames_cut, sizes_used, items_sent);
        $display("%0d results checked under four idling mixes and %0d long output hold-offs.",
                 results, holds_done);
        if (mismatches == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
